>>> sv/stevq_pkg.sv
// Shared types and constants for the simulated timer event queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package stevq_pkg;

   localparam int TIME_BITS   = 48;
   localparam int AMOUNT_BITS = 32;
   localparam int ID_BITS     = 8;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_SCHEDULE = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_ADVANCE  = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_RESERVED  = 2'd3
   } status_type;

   // Which result the datapath loads into the output register.
   typedef enum logic [1:0] {
      EMIT_ACK        = 2'd0,
      EMIT_CANCEL_HIT = 2'd1,
      EMIT_CANCEL_END = 2'd2,
      EMIT_FIRE       = 2'd3
   } emit_sel_type;

   typedef struct packed {
      logic         load;          // capture a new transaction
      kind_type     op;            // kind of the transaction at work
      logic         step;          // move the scan to the next entry
      logic         restart;       // begin a new scan pass, forget best
      logic         clear_cur;     // drop the entry under the scan index
      logic         clear_best;    // drop the best entry of the pass
      logic         commit_sched;  // store the scheduled entry if allowed
      logic         emit;          // load the output register
      emit_sel_type emit_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a result this cycle
      logic idx_last;    // scan index sits on the last entry
      logic hit;         // current entry belongs to the cancelled waiter
      logic best_found;  // the pass found a due entry
   } dp_status_type;

endpackage

>>> sv/stevq_if.sv
// Channel interfaces for request and response transactions.
// Depends on stevq_pkg for field widths.
interface stevq_req_if import stevq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_BITS-1:0]   kind;
   logic [ID_BITS-1:0]     waiter_id;
   logic [AMOUNT_BITS-1:0] amount_us;

   modport source (output valid, kind, waiter_id, amount_us, input ready);
   modport sink   (input valid, kind, waiter_id, amount_us, output ready);
endinterface

interface stevq_rsp_if import stevq_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [ID_BITS-1:0]     notified_id;
   logic                   is_notify;
   logic [STATUS_BITS-1:0] status;
   logic [TIME_BITS-1:0]   current_time_us;
   logic                   last;

   modport source (output valid, notified_id, is_notify, status, current_time_us, last,
                   input ready);
   modport sink   (input valid, notified_id, is_notify, status, current_time_us, last,
                   output ready);
endinterface

>>> sv/stevq_ctrl.sv
// Controller state machine: sequences accept, entry scan passes and results.
// Depends on stevq_pkg for the command and status structs.
module stevq_ctrl import stevq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [KIND_BITS-1:0] req_kind,
   output logic                 req_ready,
   input  dp_status_type        st,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   kind_type       kind_ff, kind_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      cmd              = '0;
      cmd.op           = kind_ff;
      cmd.emit_sel     = EMIT_ACK;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               cmd.op   = kind_type'(req_kind);
               cmd.load = 1'b1;
               state_in = (kind_type'(req_kind) == KIND_UNUSED) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // hold the scan while a cancel hit cannot be delivered
            if (!(kind_ff == KIND_CANCEL && st.hit && !st.out_free)) begin
               cmd.step = 1'b1;
               if (kind_ff == KIND_CANCEL && st.hit) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_CANCEL_HIT;
                  cmd.clear_cur = 1'b1;
               end
               if (st.idx_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
               case (kind_ff)
                  KIND_ADVANCE: begin
                     if (st.best_found) begin
                        cmd.emit_sel   = EMIT_FIRE;
                        cmd.clear_best = 1'b1;
                        cmd.restart    = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  KIND_CANCEL: begin
                     cmd.emit_sel = EMIT_CANCEL_END;
                  end
                  KIND_SCHEDULE: begin
                     cmd.commit_sched = 1'b1;
                  end
                  default: begin
                     cmd.emit_sel = EMIT_ACK;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_UNUSED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

>>> sv/stevq_dp.sv
// Datapath: time base, entry store, scan registers and the result register.
// Depends on stevq_pkg; driven by commands from stevq_ctrl.
module stevq_dp import stevq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int WAITER_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          st,
   input  logic [ID_BITS-1:0]     req_waiter_id,
   input  logic [AMOUNT_BITS-1:0] req_amount_us,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [ID_BITS-1:0]     rsp_notified_id,
   output logic                   rsp_is_notify,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [TIME_BITS-1:0]   rsp_current_time_us,
   output logic                   rsp_last
);

   localparam int IdxBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int StoreBits = (WAITER_BITS < ID_BITS) ? WAITER_BITS : ID_BITS;
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(QUEUE_DEPTH - 1);

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [AMOUNT_BITS-1:0] b);
      logic [TIME_BITS:0] sum;
      sum = {1'b0, a} + (TIME_BITS + 1)'(b);
      return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
   endfunction

   // entry store: one write port, one registered read port on the scan index
   logic [TIME_BITS-1:0] mem_due [QUEUE_DEPTH];
   logic [StoreBits-1:0] mem_wt  [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] rd_due_ff;
   logic [StoreBits-1:0] rd_wt_ff;

   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [TIME_BITS-1:0]   due_ff;
   logic [StoreBits-1:0]   w_ff;
   logic [IdxBits-1:0]     idx_ff, idx_in;

   logic                   dup_ff;
   logic                   slot_found_ff;
   logic [IdxBits-1:0]     slot_ff;
   logic                   best_found_ff;
   logic [IdxBits-1:0]     best_idx_ff;
   logic [TIME_BITS-1:0]   best_due_ff;
   logic [StoreBits-1:0]   best_wt_ff;

   logic                   out_valid_ff;
   logic [ID_BITS-1:0]     out_id_ff;
   logic                   out_notify_ff;
   status_type             out_status_ff;
   logic [TIME_BITS-1:0]   out_time_ff;
   logic                   out_last_ff;

   logic       cur_valid;
   logic       better;
   logic       out_free;
   status_type sched_status;

   assign cur_valid = valid_ff[idx_ff];
   assign better    = !best_found_ff || (rd_due_ff < best_due_ff) ||
                      ((rd_due_ff == best_due_ff) && (rd_wt_ff < best_wt_ff));
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      if (dup_ff) begin
         sched_status = STATUS_DUPLICATE;
      end else if (!slot_found_ff) begin
         sched_status = STATUS_FULL;
      end else begin
         sched_status = STATUS_OK;
      end
   end

   assign st.out_free   = out_free;
   assign st.idx_last   = (idx_ff == LastIdx);
   assign st.hit        = cur_valid && (rd_wt_ff == w_ff);
   assign st.best_found = best_found_ff;

   // next scan index, also the read address so read data tracks idx_ff
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load || cmd.restart) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = (idx_ff == LastIdx) ? '0 : idx_ff + 1'b1;
      end
   end

   always_comb begin
      now_in = now_ff;
      if (cmd.load && cmd.op == KIND_ADVANCE) begin
         now_in = sat_add(now_ff, req_amount_us);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_cur) begin
         valid_in[idx_ff] = 1'b0;
      end
      if (cmd.clear_best) begin
         valid_in[best_idx_ff] = 1'b0;
      end
      if (cmd.commit_sched && sched_status == STATUS_OK) begin
         valid_in[slot_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         valid_ff <= '0;
         idx_ff   <= '0;
      end else begin
         now_ff   <= now_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit_sched && sched_status == STATUS_OK) begin
         mem_due[slot_ff] <= due_ff;
         mem_wt[slot_ff]  <= w_ff;
      end
      rd_due_ff <= mem_due[idx_in];
      rd_wt_ff  <= mem_wt[idx_in];
   end

   // per-transaction scan state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         due_ff        <= sat_add(now_ff, req_amount_us);
         w_ff          <= req_waiter_id[StoreBits-1:0];
         dup_ff        <= 1'b0;
         slot_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
      end else if (cmd.restart) begin
         best_found_ff <= 1'b0;
      end else if (cmd.step) begin
         case (cmd.op)
            KIND_SCHEDULE: begin
               if (cur_valid && rd_due_ff == due_ff && rd_wt_ff == w_ff) begin
                  dup_ff <= 1'b1;
               end
               if (!cur_valid && !slot_found_ff) begin
                  slot_found_ff <= 1'b1;
                  slot_ff       <= idx_ff;
               end
            end
            KIND_ADVANCE: begin
               if (cur_valid && rd_due_ff <= now_ff && better) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= idx_ff;
                  best_due_ff   <= rd_due_ff;
                  best_wt_ff    <= rd_wt_ff;
               end
            end
            default: begin
               best_found_ff <= best_found_ff;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_time_ff <= now_ff;
         case (cmd.emit_sel)
            EMIT_CANCEL_HIT: begin
               out_id_ff     <= ID_BITS'(w_ff);
               out_notify_ff <= 1'b1;
               out_status_ff <= STATUS_OK;
               out_last_ff   <= 1'b0;
            end
            EMIT_CANCEL_END: begin
               out_id_ff     <= ID_BITS'(w_ff);
               out_notify_ff <= 1'b1;
               out_status_ff <= STATUS_OK;
               out_last_ff   <= 1'b1;
            end
            EMIT_FIRE: begin
               out_id_ff     <= ID_BITS'(best_wt_ff);
               out_notify_ff <= 1'b1;
               out_status_ff <= STATUS_OK;
               out_last_ff   <= 1'b0;
            end
            default: begin
               out_id_ff     <= '0;
               out_notify_ff <= 1'b0;
               out_status_ff <= (cmd.op == KIND_SCHEDULE) ? sched_status : STATUS_OK;
               out_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_notified_id     = out_id_ff;
   assign rsp_is_notify       = out_notify_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_current_time_us = out_time_ff;
   assign rsp_last            = out_last_ff;

endmodule

>>> sv/simulated_timer_event_queue_unit.sv
// Top level of the simulated timer event queue: controller plus datapath.
// Depends on stevq_pkg, stevq_if, stevq_ctrl and stevq_dp.
//
// A simulated microsecond time base (48 bits, saturating) with up to QUEUE_DEPTH
// timed wake-ups. A schedule transaction (kind 0) stores (now + amount_us,
// waiter) and returns one acknowledge whose status flags a duplicate entry or a
// full queue. A cancel transaction (kind 1) removes every entry of the waiter,
// returning one notify per removed entry and a final notify with last set. An
// advance transaction (kind 2) adds amount_us to the time, then fires every due
// entry earliest first, lowest waiter id on ties, and closes with an
// acknowledge. Kind 3 only returns an acknowledge. Every response carries the
// current time. The block works on one request at a time: req ready is high
// only when the controller is idle, while the last response may still wait in
// the output register. Entries live in a memory with one registered read port
// that a scan counter walks one entry per cycle, except that a cancel hit holds
// the scan while the output register cannot take its notify; rsp ready can also
// hold back the final response. An advance scans the entries again after each
// fired entry. No clearing pass is needed after reset: valid bits in flip-flops
// guard the entries.
module simulated_timer_event_queue_unit import stevq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int WAITER_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   stevq_req_if.sink   req_bus,
   stevq_rsp_if.source rsp_bus
);

   ctrl_cmd_type  cmd;
   dp_status_type st;

   // sequence each transaction
   stevq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // hold time, entries and the response register
   stevq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WAITER_BITS (WAITER_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_waiter_id       (req_bus.waiter_id),
      .req_amount_us       (req_bus.amount_us),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_notified_id     (rsp_bus.notified_id),
      .rsp_is_notify       (rsp_bus.is_notify),
      .rsp_status          (rsp_bus.status),
      .rsp_current_time_us (rsp_bus.current_time_us),
      .rsp_last            (rsp_bus.last)
   );

endmodule

>>> sv/stevq_checker.sv
// Port-level checks of the timer event queue, bound to the top level.
// Depends on stevq_pkg and on simulated_timer_event_queue_unit.
module stevq_checker import stevq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [ID_BITS-1:0]     rsp_notified_id,
   input logic                   rsp_is_notify,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [TIME_BITS-1:0]   rsp_current_time_us,
   input logic                   rsp_last
);

   // one transaction at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still at work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_notified_id) &&
         $stable(rsp_is_notify) && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   // simulated time never runs backward
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> rsp_current_time_us >= $past(rsp_current_time_us))
      else $error("current time decreased");

   a_refusal_is_final_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> !rsp_is_notify && rsp_last &&
         rsp_notified_id == '0)
      else $error("refusal status on a notify or non-final response");

endmodule

bind simulated_timer_event_queue_unit stevq_checker u_stevq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_notified_id     (rsp_bus.notified_id),
   .rsp_is_notify       (rsp_bus.is_notify),
   .rsp_status          (rsp_bus.status),
   .rsp_current_time_us (rsp_bus.current_time_us),
   .rsp_last            (rsp_bus.last)
);
